@@ hdl/b32e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the character map of the base32 encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

	localparam logic [4:0] SYM_MASK    = 5'h1f;
	localparam logic [4:0] ALPHA_COUNT = 5'd26;
	localparam logic [6:0] CHAR_A      = 7'h61;	// 'a'
	localparam logic [6:0] CHAR_Z      = 7'h7a;	// 'z'
	localparam logic [6:0] CHAR_2      = 7'h32;	// '2'
	localparam logic [6:0] CHAR_7      = 7'h37;	// '7'

	localparam logic [2:0] POS_FIRST = 3'd0;
	localparam logic [2:0] POS_LAST  = 3'd4;

	typedef logic [2:0] pos_t;
	typedef logic [3:0] left_t;

	typedef struct packed {
		logic [6:0] symbol;
		logic       last_of_run;
		logic       message_done;
		logic       misaligned;
	} char_t;

	typedef struct packed {
		char_t chr0;
		char_t chr1;
		logic  two;
		pos_t  next_pos;
		left_t next_left;
	} pack_res_t;

	function automatic logic [6:0] to_char(input logic [4:0] v);
		logic [4:0] d;
		d = v - ALPHA_COUNT;
		if (v < ALPHA_COUNT) begin
			return CHAR_A + {2'b00, v};
		end
		return CHAR_2 + {2'b00, d};
	endfunction

endpackage

@@ hdl/b32e_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e stream interfaces
// Byte channel into the encoder and character channel out of it.
// ----------------------------------------------------------------------------
interface b32e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface b32e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol;
	logic       last_of_run;
	logic       message_done;
	logic       misaligned;

	modport source (output valid, output symbol, output last_of_run,
		output message_done, output misaligned, input ready);
	modport sink   (input valid, input symbol, input last_of_run,
		input message_done, input misaligned, output ready);
endinterface

@@ hdl/base32_stream_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_encoder
// The first character of a byte is shown in the cycle after its beat is taken.
// Throughput: one byte per cycle at positions 0 and 2 while chars is ready;
// at 1, 3 and 4 the next byte waits until one of two characters has left;
// the two-entry register drains one character per cycle while chars is ready.
// Reset clears the group position, the leftover bits and the character count.
// ----------------------------------------------------------------------------
module base32_stream_encoder (
	input logic              clk,
	input logic              arst_n,
	b32e_byte_if.sink        octets,
	b32e_char_if.source      chars
);
	import b32e_pkg::*;

	pos_t      pos_q;
	left_t     left_q;
	char_t     head_q;
	char_t     tail_q;
	logic [1:0] cnt_q;
	pack_res_t res;
	logic      take;
	logic      pop;

	b32e_pack u_pack (
		.data_byte   (octets.data_byte),
		.end_of_data (octets.end_of_data),
		.pos         (pos_q),
		.left        (left_q),
		.res         (res)
	);

	// accept when the buffer is empty or its final character leaves now
	assign octets.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && chars.ready);
	assign take = octets.valid && octets.ready;
	assign pop  = chars.valid && chars.ready;

	assign chars.valid        = (cnt_q != 2'd0);
	assign chars.symbol       = head_q.symbol;
	assign chars.last_of_run  = head_q.last_of_run;
	assign chars.message_done = head_q.message_done;
	assign chars.misaligned   = head_q.misaligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_FIRST;
			left_q <= '0;
			cnt_q  <= 2'd0;
		end else begin
			if (take) begin
				pos_q  <= res.next_pos;
				left_q <= res.next_left;
				cnt_q  <= res.two ? 2'd2 : 2'd1;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			head_q <= res.chr0;
			tail_q <= res.chr1;
		end else if (pop) begin
			// advance the second character to the head
			head_q <= tail_q;
		end
	end

endmodule

@@ hdl/b32e_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pack
// Splits one byte plus the held bits into one or two base32 characters
// and works out the next group position and leftover bits.
// ----------------------------------------------------------------------------
module b32e_pack (
	input  logic [7:0]          data_byte,
	input  logic                end_of_data,
	input  b32e_pkg::pos_t      pos,
	input  b32e_pkg::left_t     left,
	output b32e_pkg::pack_res_t res
);
	import b32e_pkg::*;

	pos_t       p;
	logic [4:0] v0;
	logic [4:0] v1;
	left_t      nl;
	logic       two;
	logic       bad;

	always_comb begin
		// a stray position counts as the start of a group
		p = (pos > POS_LAST) ? POS_FIRST : pos;
		v1 = '0;
		unique case (p)
			3'd0: begin
				v0 = data_byte[7:3];
				nl = {1'b0, data_byte[2:0]};
				two = 1'b0;
			end
			3'd1: begin
				v0 = {left[2:0], data_byte[7:6]};
				v1 = data_byte[5:1];
				nl = {3'b000, data_byte[0]};
				two = 1'b1;
			end
			3'd2: begin
				v0 = {left[0], data_byte[7:4]};
				nl = data_byte[3:0];
				two = 1'b0;
			end
			3'd3: begin
				v0 = {left, data_byte[7]};
				v1 = data_byte[6:2];
				nl = {2'b00, data_byte[1:0]};
				two = 1'b1;
			end
			default: begin
				v0 = {left[1:0], data_byte[7:5]};
				v1 = data_byte[4:0] & SYM_MASK;
				nl = '0;
				two = 1'b1;
			end
		endcase

		bad = end_of_data && (p != POS_LAST);

		res.chr0.symbol       = to_char(v0);
		res.chr0.last_of_run  = !two;
		res.chr0.message_done = !two && end_of_data;
		res.chr0.misaligned   = bad;
		res.chr1.symbol       = to_char(v1);
		res.chr1.last_of_run  = 1'b1;
		res.chr1.message_done = end_of_data;
		res.chr1.misaligned   = bad;
		res.two               = two;

		if (end_of_data || p == POS_LAST) begin
			res.next_pos  = POS_FIRST;
			res.next_left = '0;
		end else begin
			res.next_pos  = p + 3'd1;
			res.next_left = nl;
		end
	end

endmodule

@@ hdl/b32e_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_checker
// Port-level checks on the character stream of the base32 encoder.
// ----------------------------------------------------------------------------
module b32e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] symbol,
	input logic       last_of_run,
	input logic       message_done,
	input logic       misaligned
);
	import b32e_pkg::*;

	// a stalled beat holds its character
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol)
			&& $stable(last_of_run) && $stable(misaligned))
		else $error("character changed while stalled");

	// the second character of a byte follows at once with the same flag
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid
			&& misaligned == $past(misaligned) && last_of_run)
		else $error("second character of a byte missing");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((symbol >= CHAR_A && symbol <= CHAR_Z)
			|| (symbol >= CHAR_2 && symbol <= CHAR_7))
			&& (!message_done || last_of_run))
		else $error("character outside alphabet or early end");

	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("valid during reset");

endmodule

bind base32_stream_encoder b32e_checker u_b32e_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (chars.valid),
	.out_ready    (chars.ready),
	.symbol       (chars.symbol),
	.last_of_run  (chars.last_of_run),
	.message_done (chars.message_done),
	.misaligned   (chars.misaligned)
);
